// ----- rtl/core/sum_pkg.sv -----
// Shared types and codes for the sorted union merge block.
// Holds operation codes and the controller/datapath command and status structs.
`default_nettype none
package sum_pkg;

  localparam int unsigned OpW = 2;
  localparam int unsigned ValW = 32;

  localparam logic [OpW-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OpW-1:0] OP_MERGE  = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic emit_pend;
    logic emit_last;
    logic emit_empty;
  } sum_cmd_t;

  typedef struct packed {
    logic out_free;
    logic both_empty;
    logic emit_needed;
    logic last_step;
  } sum_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/sum_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sum_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/sum_ctrl.sv -----
// Controller state machine for the sorted union merge block.
// Depends on sum_pkg; drives sum_dpath through command and status structs.
`default_nettype none
module sum_ctrl
  import sum_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire logic [OpW-1:0] in_op,
  output logic                in_tready,
  input  wire sum_sts_t       sts,
  output sum_cmd_t            cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_MERGE: begin
              cmd.start = 1'b1;
              state_nxt = sts.both_empty ? ST_EMPTY : ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (!sts.emit_needed || sts.out_free) begin
          cmd.step      = 1'b1;
          cmd.emit_pend = sts.emit_needed;
          if (sts.last_step) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sum_dpath.sv -----
// Datapath: list RAMs, counts, read pointers, pending value and output register.
// Depends on sum_pkg and sum_ram; controlled by sum_ctrl.
`default_nettype none
module sum_dpath
  import sum_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [ValW-1:0] in_value,
  input  wire sum_cmd_t        cmd,
  output sum_sts_t             sts,
  input  wire logic            out_tready,
  output logic                 out_tvalid,
  output logic      [ValW-1:0] out_value,
  output logic                 out_last,
  output logic                 out_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [CW-1:0]   cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]   na_r, na_nxt, nb_r, nb_nxt;
  logic [CW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [ValW-1:0] pend_r, pend_nxt;
  logic            have_r, have_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ValW-1:0] out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_empty_r, out_empty_nxt;

  logic            we_a, we_b;
  logic [ValW-1:0] head_a, head_b, pick;
  logic            a_left, b_left, take_a, distinct;

  assign we_a = cmd.load_a && (cnt_a_r < Full);
  assign we_b = cmd.load_b && (cnt_b_r < Full);

  sum_ram #(.WIDTH(ValW), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .we      (we_a),
    .waddr   (cnt_a_r[AW-1:0]),
    .wdata   (in_value),
    .raddr   (i_nxt[AW-1:0]),
    .rdata_r (head_a)
  );

  sum_ram #(.WIDTH(ValW), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .we      (we_b),
    .waddr   (cnt_b_r[AW-1:0]),
    .wdata   (in_value),
    .raddr   (j_nxt[AW-1:0]),
    .rdata_r (head_b)
  );

  assign a_left   = i_r < na_r;
  assign b_left   = j_r < nb_r;
  assign take_a   = a_left && (!b_left || ($signed(head_a) <= $signed(head_b)));
  assign pick     = take_a ? head_a : head_b;
  assign distinct = !have_r || (pick != pend_r);

  always_comb begin
    sts.out_free    = !out_valid_r || out_tready;
    sts.both_empty  = (cnt_a_r == '0) && (cnt_b_r == '0);
    sts.emit_needed = have_r && (pick != pend_r);
    sts.last_step   = take_a ? ((i_r + CW'(1) == na_r) && !b_left)
                             : ((j_r + CW'(1) == nb_r) && !a_left);
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pend_nxt  = pend_r;
    have_nxt  = have_r;
    if (we_a) begin
      cnt_a_nxt = cnt_a_r + CW'(1);
    end
    if (we_b) begin
      cnt_b_nxt = cnt_b_r + CW'(1);
    end
    if (cmd.start) begin
      na_nxt    = cnt_a_r;
      nb_nxt    = cnt_b_r;
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      i_nxt     = '0;
      j_nxt     = '0;
      have_nxt  = 1'b0;
    end
    if (cmd.step) begin
      if (take_a) begin
        i_nxt = i_r + CW'(1);
      end else begin
        j_nxt = j_r + CW'(1);
      end
      if (distinct) begin
        pend_nxt = pick;
        have_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    if (cmd.emit_pend || cmd.emit_last) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = pend_r;
      out_last_nxt  = cmd.emit_last;
      out_empty_nxt = 1'b0;
    end else if (cmd.emit_empty) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = '0;
      out_last_nxt  = 1'b1;
      out_empty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r      <= pend_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign out_empty  = out_empty_r;

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= Full) && (cnt_b_r <= Full))
    else $error("list count beyond depth");

  a_ptrs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (i_r <= na_r) && (j_r <= nb_r))
    else $error("read pointer beyond list length");

  a_step_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (a_left || b_left))
    else $error("merge step with both lists exhausted");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty result not flagged last");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_pend || cmd.emit_last || cmd.emit_empty) |-> (!out_valid_r || out_tready))
    else $error("result overwrites unsent beat");

endmodule
`default_nettype wire

// ----- rtl/core/sorted_union_merge.sv -----
// Top level of the sorted union merge block.
// Depends on sum_pkg, sum_ctrl, sum_dpath and sum_ram.
//
// Input channel in_*: each beat carries an operation and a value. Operation
// load A or load B appends the value to that list (dropped once the list holds
// DEPTH values) and gives no result; one load is taken per cycle while no
// merge runs. Operation merge walks both lists with two read pointers, one
// element per cycle unless a stalled receiver holds the walk, and streams the
// distinct values of the union in ascending signed order on out_*, with
// out_tlast on the final beat; both lists are emptied when the merge is taken.
// A merge of two empty lists gives one beat with out_tuser and out_tlast set.
// A merge holds the input channel until its final result enters the output
// register; a value result passes the pending value register before it.
// The walk rate is set by the single read port of each list RAM.
// The result leaves through an output register: a stalled receiver holds
// the walk only when a new distinct value must be sent; loads are still taken
// while a result waits. Reset empties both lists and the output register.
`default_nettype none
module sorted_union_merge
  import sum_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [1:0] operation, [33:2] value, [39:34] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] union_value
  output logic             out_tlast,
  output logic      [0:0]  out_tuser   // [0] empty_res
);

  sum_cmd_t cmd;
  sum_sts_t sts;

  sum_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tdata[OpW-1:0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sum_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[OpW+ValW-1:OpW]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_value  (out_tdata),
    .out_last   (out_tlast),
    .out_empty  (out_tuser[0])
  );

endmodule
`default_nettype wire
